// File: rtl/lds_pkg.sv
// shared types, constants and rounding helpers for the lens disk sample offset block
package lds_pkg;

	localparam int unsigned DATA_W      = 34;
	localparam int unsigned MUL_B_W     = 17;
	localparam int unsigned PROD_W      = DATA_W + MUL_B_W;
	localparam int unsigned OUT_W       = 17;
	localparam int unsigned ATAN_ENTRIES = 24;
	localparam int unsigned IDX_W       = 5;
	localparam int unsigned CFG_IDX_W   = 2;

	localparam logic [15:0] GAIN_Q16    = 16'd39797;
	localparam logic [15:0] RADIUS_RST  = 16'd1280;
	localparam logic [15:0] FRAME_MAX   = 16'hFFFF;

	localparam logic [CFG_IDX_W-1:0] REG_LENS_RADIUS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_SCALE = CFG_IDX_W'(1);

	localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [OUT_W-1:0]  out_t;

	function automatic out_t clamp_out(input prod_t t);
		if (t > prod_t'(65535))
			return out_t'(65535);
		else if (t < -prod_t'(65535))
			return -out_t'(65535);
		else
			return out_t'(t);
	endfunction

	// q2.30 times q8.8, round to q8.8
	function automatic out_t sat_lens(input prod_t p);
		prod_t t;
		t = (p + (prod_t'(1) <<< 29)) >>> 30;
		return clamp_out(t);
	endfunction

	// q8.8 times q0.16, optionally negated, round to q8.8
	function automatic out_t sat_shift(input prod_t p, input logic neg);
		prod_t q;
		prod_t t;
		q = neg ? -p : p;
		t = (q + prod_t'(32768)) >>> 16;
		return clamp_out(t);
	endfunction

endpackage

// File: rtl/lds_isqrt.sv
// bit-pair iterative integer square root of u * 2^16
module lds_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] u,
	output logic        done,
	output logic [15:0] root
);
	logic [31:0] n_q;
	logic [31:0] res_q;
	logic [31:0] bit_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= {u, 16'd0};
			res_q <= '0;
			bit_q <= 32'd1 << 30;
		end else if (busy_q) begin
			if (n_q >= trial) begin
				n_q   <= n_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[15:0];
endmodule

// File: rtl/lds_cordic.sv
// iterative rotation-mode cordic, one micro-rotation per cycle
module lds_cordic #(
	parameter int unsigned ITERS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [29:0]         x0,
	input  logic [29:0]         z0,
	output logic                done,
	output lds_pkg::data_t      x,
	output lds_pkg::data_t      y
);
	import lds_pkg::*;

	data_t            x_q;
	data_t            y_q;
	data_t            z_q;
	logic [IDX_W-1:0] i_q;
	logic             busy_q;
	logic             done_q;
	data_t            dx;
	data_t            dy;
	data_t            ang;

	assign dx  = y_q >>> i_q;
	assign dy  = x_q >>> i_q;
	assign ang = $signed({{(DATA_W-32){1'b0}}, ATAN_TAB[i_q]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				if (i_q == IDX_W'(ITERS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					i_q <= i_q + IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= $signed({{(DATA_W-30){1'b0}}, x0});
			y_q <= '0;
			z_q <= $signed({{(DATA_W-30){1'b0}}, z0});
		end else if (busy_q) begin
			if (!z_q[DATA_W-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - ang;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + ang;
			end
		end
	end

	assign done = done_q;
	assign x    = x_q;
	assign y    = y_q;
endmodule

// File: rtl/lens_disk_sample_offset.sv
// Lens disk sample offset: maps a pair of uniform Q0.16 fractions onto the unit disk (radius
// sqrt(u), angle 2*pi*v), scales by the lens radius and derives the image shift, with a
// saturating frame counter. One beat is processed at a time, from input accept to output
// valid, in order: the bit-pair square root, the SEED and CSTART states that form the cordic
// seed, the cordic rotation of CORDIC_ITERATIONS steps (capped at 24 steps), and the four
// products through the single shared 34x17 multiplier followed by the output load. The next
// beat can be taken in the same cycle that output valid rises, so a new beat is accepted
// only once the last one has reached the output register.
// in_stall stays high while a beat is in flight; a finished beat may wait in the output
// register while the next one is accepted, and a beat in its last phase waits there while
// the output register is held. No clearing pass follows reset.
module lens_disk_sample_offset #(
	parameter int unsigned CORDIC_ITERATIONS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [15:0]                            rand_u,
	input  logic [15:0]                            rand_v,
	input  logic                                   restart,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [16:0]                     lens_x,
	output logic signed [16:0]                     lens_y,
	output logic signed [16:0]                     shift_x,
	output logic signed [16:0]                     shift_y,
	output logic [15:0]                            frame_count,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [lds_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [15:0]                            cfg_data
);
	import lds_pkg::*;

	localparam int unsigned N_ITER =
		(CORDIC_ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_ITERATIONS;

	typedef enum logic [3:0] {
		IDLE, SQRT, SEED, CSTART, CORD, MX, MY, SX, SY, FIN
	} state_t;

	state_t        state_q;
	logic [15:0]   radius_q;
	logic [15:0]   scale_q;
	logic [15:0]   frame_q;
	logic [13:0]   vres_q;
	logic [1:0]    quad_q;
	prod_t         prod_q;
	out_t          lx_q;
	out_t          ly_q;
	out_t          sx_q;
	logic          out_valid_q;
	out_t          lens_x_q;
	out_t          lens_y_q;
	out_t          shift_x_q;
	out_t          shift_y_q;
	logic [15:0]   frame_out_q;

	logic          in_acc;
	logic          out_free;
	logic          sqrt_done;
	logic [15:0]   root;
	logic          cord_done;
	data_t         cord_x;
	data_t         cord_y;
	data_t         cx;
	data_t         cy;
	data_t         mul_a;
	logic [MUL_B_W-1:0] mul_b;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	lds_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_acc),
		.u      (rand_u),
		.done   (sqrt_done),
		.root   (root)
	);

	lds_cordic #(
		.ITERS (N_ITER)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == CSTART),
		.x0     (prod_q[31:2]),
		.z0     ({vres_q, 16'd0}),
		.done   (cord_done),
		.x      (cord_x),
		.y      (cord_y)
	);

	// quadrant rotation by multiples of 90 degrees
	always_comb begin
		unique case (quad_q)
			2'd0: begin cx = cord_x;  cy = cord_y;  end
			2'd1: begin cx = -cord_y; cy = cord_x;  end
			2'd2: begin cx = -cord_x; cy = -cord_y; end
			default: begin cx = cord_y; cy = -cord_x; end
		endcase
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			SEED: begin
				mul_a = $signed({{(DATA_W-16){1'b0}}, root});
				mul_b = {1'b0, GAIN_Q16};
			end
			MX: begin
				mul_a = cx;
				mul_b = {1'b0, radius_q};
			end
			MY: begin
				mul_a = cy;
				mul_b = {1'b0, radius_q};
			end
			SX: begin
				mul_a = DATA_W'(lx_q);
				mul_b = {1'b0, scale_q};
			end
			SY: begin
				mul_a = DATA_W'(ly_q);
				mul_b = {1'b0, scale_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		// product held in the last phase while the output register is busy
		if (state_q != FIN)
			prod_q <= mul_a * $signed(mul_b);
		if (in_acc) begin
			vres_q <= rand_v[13:0];
			quad_q <= rand_v[15:14];
		end
		if (state_q == MY)
			lx_q <= sat_lens(prod_q);
		if (state_q == SX)
			ly_q <= sat_lens(prod_q);
		if (state_q == SY)
			sx_q <= sat_shift(prod_q, 1'b1);
		if (state_q == FIN && out_free) begin
			lens_x_q    <= lx_q;
			lens_y_q    <= ly_q;
			shift_x_q   <= sx_q;
			shift_y_q   <= sat_shift(prod_q, 1'b0);
			frame_out_q <= frame_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
			radius_q    <= RADIUS_RST;
			scale_q     <= '0;
			frame_q     <= 16'd1;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_LENS_RADIUS)
					radius_q <= cfg_data;
				else if (cfg_index == REG_SHIFT_SCALE)
					scale_q <= cfg_data;
			end
			if (state_q == FIN && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (in_acc) begin
						state_q <= SQRT;
						if (restart)
							frame_q <= 16'd2;
						else if (frame_q != FRAME_MAX)
							frame_q <= frame_q + 16'd1;
					end
				end
				SQRT:   if (sqrt_done) state_q <= SEED;
				SEED:   state_q <= CSTART;
				CSTART: state_q <= CORD;
				CORD:   if (cord_done) state_q <= MX;
				MX:     state_q <= MY;
				MY:     state_q <= SX;
				SX:     state_q <= SY;
				SY:     state_q <= FIN;
				FIN: begin
					if (out_free)
						state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign lens_x      = lens_x_q;
	assign lens_y      = lens_y_q;
	assign shift_x     = shift_x_q;
	assign shift_y     = shift_y_q;
	assign frame_count = frame_out_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("input taken without entering busy");

	a_frame_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		frame_q != 16'd0)
		else $error("frame counter wrapped to zero");

	a_sqrt_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_done |-> state_q == SQRT)
		else $error("square root finished outside its phase");

	a_cord_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		cord_done |-> state_q == CORD)
		else $error("rotation finished outside its phase");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == FIN))
		else $error("output beat raised outside the final phase");
endmodule
